### hw/rtl/bka_pkg.sv
`timescale 1ns / 1ps

package bka_pkg;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 10;
  localparam int CFG_W    = 11;
  localparam int SIZE_W   = 11;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

  // register indexes
  localparam logic CFG_KEY_LIMIT  = 1'b0;
  localparam logic CFG_GROW_CHUNK = 1'b1;

  // external size saturates here
  localparam logic [SIZE_W-1:0] SIZE_MAX = 11'h7FF;

endpackage

### hw/rtl/bka_ffz.sv
`timescale 1ns / 1ps

// Find first zero: lowest clear bit of a word.
module bka_ffz #(
  parameter int WIDTH = 32,
  parameter int POS_W = 5
) (
  input  logic [WIDTH-1:0] word_i,
  output logic             found_o,
  output logic [POS_W-1:0] pos_o
);

  always_comb begin
    found_o = ~&word_i;
    pos_o   = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        pos_o = POS_W'(i);
      end
    end
  end

endmodule

### hw/rtl/bka_page_ram.sv
`timescale 1ns / 1ps

// Page store: one write port, one registered read port.
module bka_page_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bitmap_key_allocator.sv
`timescale 1ns / 1ps

// Bitmap key allocator. Hands out the lowest free key below KEY_CAPACITY
// (reserve), frees a held key (release) or empties the whole map (clear);
// every input word yields exactly one result word. Held bits live in a
// page store of PAGE_BITS-wide pages (PAGE_BITS a power of two), with one
// page-full flag and one page-valid flag per page in flops, so a clear
// takes effect at once and no clearing pass follows reset. A reserve scans
// the page-full flags one PAGE_BITS chunk per cycle, reads the chosen page,
// then picks its lowest clear bit; both searches share one find-first-zero
// unit. A new input word is taken only once the last one's result word is
// loaded. A reserve steps through scan, read and update; a release in range
// reads the page, then clears the bit; a clear, an unknown word and a reserve
// refused at the limit go straight to the final step; a reserve that finds
// every page full, or whose only free bit lies past capacity in a partial
// last page, ends in the final step after the scan or the read.
// Results sit in an output register, and a stalled output holds the
// sequencer in its final step. Registers: key_limit (0 = full capacity),
// grow_chunk (0 = never request growth); write them only while idle.
module bitmap_key_allocator import bka_pkg::*; #(
  parameter int KEY_CAPACITY = 1024,
  parameter int PAGE_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [KEY_W-1:0]    in_release_key,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_ok,
  output logic [KEY_W-1:0]    out_key,
  output logic                out_grow_request,
  output logic [SIZE_W-1:0]   out_grow_size
);

  localparam int NUM_PAGES = (KEY_CAPACITY + PAGE_BITS - 1) / PAGE_BITS;
  localparam int PW        = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int BW        = $clog2(PAGE_BITS);
  localparam int KW        = PW + BW;
  localparam int CW        = $clog2(KEY_CAPACITY + 1);
  localparam int NCHUNK    = (NUM_PAGES + PAGE_BITS - 1) / PAGE_BITS;
  localparam int CHW       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int FW        = NCHUNK * PAGE_BITS;

  // flags past the last real page read as full so the scan skips them
  localparam logic [FW-1:0]  FULL_PAD   = ~({FW{1'b1}} >> (FW - NUM_PAGES));
  localparam logic [KW:0]    CAP_K      = (KW + 1)'(KEY_CAPACITY);
  localparam logic [CW-1:0]  CAP_C      = CW'(KEY_CAPACITY);
  localparam logic [CHW-1:0] LAST_CHUNK = CHW'(NCHUNK - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,   // search page-full flags, one chunk a cycle
    S_RD,     // page data back: pick lowest clear bit, mark it
    S_UPD,    // highest key / grow request, emit result
    S_REL,    // page data back: clear bit, emit result
    S_FIN     // emit a staged result
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0]     key_limit_r;
  logic [CFG_W-1:0]     grow_chunk_r;
  logic [NUM_PAGES-1:0] pvalid_r;
  logic [FW-1:0]        full_r;
  logic [CW-1:0]        count_r;
  logic [KW-1:0]        highest_r;
  logic [SIZE_W-1:0]    ext_r;

  logic [CHW-1:0]       chunk_r;
  logic [PW-1:0]        page_r;
  logic [BW-1:0]        bit_r;
  logic [KW-1:0]        key_r;
  logic [KEY_W-1:0]     rkey_r;
  logic                 rd_valid_r;

  logic                 res_ok_r;
  logic [KEY_W-1:0]     res_key_r;
  logic                 res_grow_r;
  logic [SIZE_W-1:0]    res_size_r;

  logic                 out_valid_r;
  logic                 out_ok_r;
  logic [KEY_W-1:0]     out_key_r;
  logic                 out_grow_r;
  logic [SIZE_W-1:0]    out_size_r;

  logic                 in_fire;
  logic                 slot_free;
  logic                 emit;
  logic                 limit_ok;
  logic                 rel_in_range;
  logic [PW-1:0]        rel_page;
  logic [BW-1:0]        rel_bit;
  logic [PAGE_BITS-1:0] summary;
  logic [PAGE_BITS-1:0] rd_data;
  logic [PAGE_BITS-1:0] page_word;
  logic [PAGE_BITS-1:0] ffz_word;
  logic                 ffz_found;
  logic [BW-1:0]        ffz_pos;
  logic [CHW+BW-1:0]    scan_page_wide;
  logic [PW-1:0]        scan_page;
  logic [KW-1:0]        rd_key;
  logic                 rd_key_ok;
  logic [PAGE_BITS-1:0] new_word;
  logic [PAGE_BITS-1:0] rel_mask;
  logic                 rel_held;
  logic                 grow_hi;
  logic [SIZE_W:0]      size_sum;
  logic [SIZE_W-1:0]    size_sat;
  logic                 grow_need;

  logic                 ram_we;
  logic [PAGE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [PW-1:0]        ram_raddr;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // a final step loads a new result word this cycle
  assign emit = slot_free &&
                ((state_r == S_UPD) || (state_r == S_REL) || (state_r == S_FIN));

  // a limit above capacity lets the search itself refuse
  assign limit_ok = (key_limit_r == '0) ? (count_r < CAP_C)
                                        : (32'(count_r) < 32'(key_limit_r));

  assign rel_in_range = 32'(in_release_key) < 32'(KEY_CAPACITY);
  assign rel_page     = PW'(in_release_key >> BW);
  assign rel_bit      = BW'(in_release_key);

  assign summary   = full_r[chunk_r*PAGE_BITS +: PAGE_BITS];
  // pages never written since clear read as empty
  assign page_word = rd_valid_r ? rd_data : '0;

  // shared search unit: flags while scanning, page data afterwards
  assign ffz_word = (state_r == S_SCAN) ? summary : page_word;

  bka_ffz #(
    .WIDTH (PAGE_BITS),
    .POS_W (BW)
  ) u_ffz (
    .word_i  (ffz_word),
    .found_o (ffz_found),
    .pos_o   (ffz_pos)
  );

  assign scan_page_wide = {chunk_r, ffz_pos};
  assign scan_page      = scan_page_wide[PW-1:0];

  // a free bit past capacity in a partial last page means no key left
  assign rd_key    = {page_r, ffz_pos};
  assign rd_key_ok = (KW + 1)'(rd_key) < CAP_K;
  assign new_word  = page_word | (PAGE_BITS'(1) << ffz_pos);

  assign rel_mask = PAGE_BITS'(1) << bit_r;
  assign rel_held = |(page_word & rel_mask);

  // grow by one chunk (saturating at SIZE_MAX) on a new highest key beyond the size
  assign grow_hi   = key_r > highest_r;
  assign size_sum  = (SIZE_W + 1)'(ext_r) + (SIZE_W + 1)'(grow_chunk_r);
  assign size_sat  = size_sum[SIZE_W] ? SIZE_MAX : size_sum[SIZE_W-1:0];
  assign grow_need = grow_hi && (grow_chunk_r != '0) && (32'(key_r) > 32'(ext_r));

  assign ram_re    = ((state_r == S_SCAN) && ffz_found) ||
                     (in_fire && (in_action == ACT_RELEASE) && rel_in_range);
  assign ram_raddr = (state_r == S_SCAN) ? scan_page : rel_page;
  assign ram_we    = ((state_r == S_RD) && rd_key_ok) ||
                     ((state_r == S_REL) && slot_free && rel_held);
  assign ram_wdata = (state_r == S_RD) ? new_word : (page_word & ~rel_mask);

  bka_page_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (PAGE_BITS),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (page_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      key_limit_r  <= '0;
      grow_chunk_r <= '0;
      pvalid_r     <= '0;
      full_r       <= FULL_PAD;
      count_r      <= '0;
      highest_r    <= '0;
      ext_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_LIMIT:  key_limit_r  <= cfg_wdata;
          CFG_GROW_CHUNK: grow_chunk_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (ram_re) begin
        rd_valid_r <= pvalid_r[ram_raddr];
      end

      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            rkey_r     <= in_release_key;
            res_ok_r   <= 1'b0;
            res_key_r  <= '0;
            res_grow_r <= 1'b0;
            res_size_r <= '0;
            unique case (in_action)
              ACT_RESERVE: begin
                if (limit_ok) begin
                  chunk_r <= '0;
                  state_r <= S_SCAN;
                end else begin
                  state_r <= S_FIN;
                end
              end
              ACT_RELEASE: begin
                if (rel_in_range) begin
                  page_r  <= rel_page;
                  bit_r   <= rel_bit;
                  state_r <= S_REL;
                end else begin
                  res_key_r <= in_release_key;
                  state_r   <= S_FIN;
                end
              end
              ACT_CLEAR: begin
                pvalid_r  <= '0;
                full_r    <= FULL_PAD;
                count_r   <= '0;
                highest_r <= '0;
                ext_r     <= '0;
                res_ok_r  <= 1'b1;
                state_r   <= S_FIN;
              end
              default: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (ffz_found) begin
            page_r  <= scan_page;
            state_r <= S_RD;
          end else if (chunk_r == LAST_CHUNK) begin
            state_r <= S_FIN;
          end else begin
            chunk_r <= chunk_r + 1'b1;
          end
        end

        S_RD: begin
          if (rd_key_ok) begin
            pvalid_r[page_r] <= 1'b1;
            full_r[page_r]   <= &new_word;
            count_r          <= CW'(count_r + 1'b1);
            key_r            <= rd_key;
            state_r          <= S_UPD;
          end else begin
            state_r <= S_FIN;
          end
        end

        S_UPD: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b1;
            out_key_r   <= KEY_W'(key_r);
            out_grow_r  <= grow_need;
            out_size_r  <= grow_need ? size_sat : '0;
            if (grow_hi) begin
              highest_r <= key_r;
            end
            if (grow_need) begin
              ext_r <= size_sat;
            end
            state_r <= S_IDLE;
          end
        end

        S_REL: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= rel_held;
            out_key_r   <= rkey_r;
            out_grow_r  <= 1'b0;
            out_size_r  <= '0;
            if (rel_held) begin
              pvalid_r[page_r] <= 1'b1;
              full_r[page_r]   <= 1'b0;
              if (count_r != '0) begin
                count_r <= count_r - 1'b1;
              end
            end
            state_r <= S_IDLE;
          end
        end

        S_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_key_r   <= res_key_r;
            out_grow_r  <= res_grow_r;
            out_size_r  <= res_size_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_key          = out_key_r;
  assign out_grow_request = out_grow_r;
  assign out_grow_size    = out_size_r;

endmodule

### hw/rtl/bka_checker.sv
`timescale 1ns / 1ps

module bka_checker import bka_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_ok,
  input logic [KEY_W-1:0]    out_key,
  input logic                out_grow_request,
  input logic [SIZE_W-1:0]   out_grow_size
);

  // one word in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

  // stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_ok) && $stable(out_key) &&
      $stable(out_grow_request) && $stable(out_grow_size))
    else $error("stalled result word changed");

  // growth only comes with a granted key
  a_grow_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grow_request |-> out_ok)
    else $error("grow request without a grant");

  a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_grow_request |-> out_grow_size == '0)
    else $error("grow size set without grow request");

endmodule

bind bitmap_key_allocator bka_checker u_bka_checker (.*);
